// File: hw/rtl/vgmcsp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vgmcsp_pkg
// Shared types, codes and constants for the sound-chip command stream parser.
// ----------------------------------------------------------------------------
package vgmcsp_pkg;

  // result kind
  typedef logic [1:0] kind_t;

  localparam kind_t KIND_WRITE = 2'd0;
  localparam kind_t KIND_WAIT  = 2'd1;
  localparam kind_t KIND_END   = 2'd2;
  localparam kind_t KIND_ERR   = 2'd3;

  // parser phase codes
  localparam logic [2:0] PH_CMD  = 3'd0;
  localparam logic [2:0] PH_ADDR = 3'd1;
  localparam logic [2:0] PH_DATA = 3'd2;
  localparam logic [2:0] PH_WLO  = 3'd3;
  localparam logic [2:0] PH_WHI  = 3'd4;
  localparam logic [2:0] PH_HALT = 3'd5;

  // command bytes
  localparam logic [7:0] CMD_REG_WRITE = 8'h55;
  localparam logic [7:0] CMD_WAIT_16   = 8'h61;
  localparam logic [7:0] CMD_WAIT_NTSC = 8'h62;
  localparam logic [7:0] CMD_WAIT_PAL  = 8'h63;
  localparam logic [7:0] CMD_END       = 8'h66;
  localparam logic [7:0] CMD_SHORT_LO  = 8'h70;
  localparam logic [7:0] CMD_SHORT_HI  = 8'h7F;
  localparam logic [7:0] SHORT_BIAS    = 8'h6F;

  // fixed wait lengths in samples
  localparam logic [15:0] WAIT_NTSC = 16'd735;
  localparam logic [15:0] WAIT_PAL  = 16'd882;

  localparam logic [31:0] LIMIT_RESET = 32'hFFFF_FFFF;

endpackage
`default_nettype wire

// File: hw/rtl/vgm_command_stream_parser_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vgm_command_stream_parser_top
// Parses a sound-chip command stream body byte by byte into register writes,
// waits, end of data and error results, with a command count limit.
// ----------------------------------------------------------------------------
// Timing: a result appears in the output register in the cycle after the byte
// that finishes its command is accepted.
// Throughput: one byte per cycle while the output register is not stalled; the
// single decode stage between the phase register and the output register sets it.
// Reset (rst, synchronous): parser expects a command byte, count and held
// bytes cleared, limit set to all ones, output register empty.
module vgm_command_stream_parser_top (
  input  wire                 clk,
  input  wire                 rst,
  // byte channel
  input  wire                 byte_valid,
  output logic                byte_stall,
  input  wire  [7:0]          stream_byte,
  // result channel
  output logic                result_valid,
  input  wire                 result_stall,
  output vgmcsp_pkg::kind_t   kind,
  output logic [7:0]          reg_address,
  output logic [7:0]          reg_value,
  output logic [15:0]         wait_samples,
  output logic                last_of_stream,
  // limit register write channel
  input  wire                 limit_valid,
  output logic                limit_ready,
  input  wire  [31:0]         command_limit
);
  import vgmcsp_pkg::*;

  logic [2:0]  phase, phase_next;
  logic [7:0]  held_address, held_address_next;
  logic [7:0]  held_wait_low, held_wait_low_next;
  logic [31:0] command_count, command_count_next;
  logic [31:0] stop_limit;

  logic        byte_take;
  logic        limit_take;
  logic        out_free;

  logic [1:0]  count_inc;
  logic [32:0] count_sum;
  logic [31:0] count_sat;
  logic        limit_hit;

  logic        emit;
  kind_t       res_kind;
  logic [7:0]  res_address;
  logic [7:0]  res_value;
  logic [15:0] res_wait;
  logic        res_last;

  // handshakes
  assign out_free    = !result_valid || !result_stall;
  assign byte_stall  = !out_free;
  assign byte_take   = byte_valid && !byte_stall;
  assign limit_ready = 1'b1;
  assign limit_take  = limit_valid && limit_ready;

  // saturating command count and limit compare
  assign count_inc = ((phase == PH_DATA) || (phase == PH_WHI)) ? 2'd2 : 2'd1;
  assign count_sum = {1'b0, command_count} + {31'b0, count_inc};
  assign count_sat = count_sum[32] ? LIMIT_RESET : count_sum[31:0];
  assign limit_hit = (count_sat >= stop_limit);

  // byte decode
  always_comb begin
    phase_next         = phase;
    held_address_next  = held_address;
    held_wait_low_next = held_wait_low;
    command_count_next = command_count;
    emit               = 1'b0;
    res_kind           = KIND_WAIT;
    res_address        = 8'd0;
    res_value          = 8'd0;
    res_wait           = 16'd0;
    res_last           = 1'b0;
    unique case (phase)
      PH_CMD: begin
        case (stream_byte) inside
          CMD_REG_WRITE: phase_next = PH_ADDR;
          CMD_WAIT_16:   phase_next = PH_WLO;
          CMD_WAIT_NTSC, CMD_WAIT_PAL: begin
            emit               = 1'b1;
            res_wait           = (stream_byte == CMD_WAIT_NTSC) ? WAIT_NTSC : WAIT_PAL;
            res_last           = limit_hit;
            command_count_next = count_sat;
            phase_next         = limit_hit ? PH_HALT : PH_CMD;
          end
          [CMD_SHORT_LO:CMD_SHORT_HI]: begin
            emit               = 1'b1;
            res_wait           = {8'd0, stream_byte - SHORT_BIAS};
            res_last           = limit_hit;
            command_count_next = count_sat;
            phase_next         = limit_hit ? PH_HALT : PH_CMD;
          end
          CMD_END: begin
            emit               = 1'b1;
            res_kind           = KIND_END;
            res_last           = 1'b1;
            command_count_next = stop_limit;
            phase_next         = PH_HALT;
          end
          default: begin
            emit       = 1'b1;
            res_kind   = KIND_ERR;
            res_value  = stream_byte;
            res_last   = 1'b1;
            phase_next = PH_HALT;
          end
        endcase
      end
      PH_ADDR: begin
        held_address_next = stream_byte;
        phase_next        = PH_DATA;
      end
      PH_DATA: begin
        emit               = 1'b1;
        res_kind           = KIND_WRITE;
        res_address        = held_address;
        res_value          = stream_byte;
        res_last           = limit_hit;
        command_count_next = count_sat;
        phase_next         = limit_hit ? PH_HALT : PH_CMD;
      end
      PH_WLO: begin
        held_wait_low_next = stream_byte;
        phase_next         = PH_WHI;
      end
      PH_WHI: begin
        emit               = 1'b1;
        res_wait           = {stream_byte, held_wait_low};
        res_last           = limit_hit;
        command_count_next = count_sat;
        phase_next         = limit_hit ? PH_HALT : PH_CMD;
      end
      default: ;
    endcase
  end

  // parser state, limit write rearms
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_CMD;
      held_address  <= 8'd0;
      held_wait_low <= 8'd0;
      command_count <= 32'd0;
      stop_limit    <= LIMIT_RESET;
    end else if (limit_take) begin
      phase         <= PH_CMD;
      held_address  <= 8'd0;
      held_wait_low <= 8'd0;
      command_count <= 32'd0;
      stop_limit    <= command_limit;
    end else if (byte_take) begin
      phase         <= phase_next;
      held_address  <= held_address_next;
      held_wait_low <= held_wait_low_next;
      command_count <= command_count_next;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= byte_take && emit && !limit_take;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (byte_take && emit && !limit_take) begin
      kind           <= res_kind;
      reg_address    <= res_address;
      reg_value      <= res_value;
      wait_samples   <= res_wait;
      last_of_stream <= res_last;
    end
  end

  // halted parser stays halted until the limit is written
  a_halt_holds: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_HALT) && !limit_take |=> (phase == PH_HALT))
    else $error("parser left halt without a limit write");

  // a byte taken while halted gives no result
  a_halt_silent: assert property (@(posedge clk) disable iff (rst)
    byte_take && (phase == PH_HALT) && !limit_take |=> !result_valid)
    else $error("result produced while halted");

  // end and error results always finish the stream
  a_end_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && ((kind == KIND_END) || (kind == KIND_ERR)) |-> last_of_stream)
    else $error("end or error result not marked last");

endmodule
`default_nettype wire
